// ----- hw/rtl/cau_pkg.sv -----
// Shared types, constants and helpers for the complex arithmetic unit.
// No dependencies; every other file of the block but cau_checker uses this package.
`default_nettype none
package cau_pkg;

  // Default number of fraction bits of the fixed-point operands.
  localparam int FRAC_BITS = 8;
  // Width of the shifted divide numerator; covers FRAC_BITS up to 17.
  localparam int NW = 49;
  // Quotient bits produced by the divide iterations.
  localparam int QW = 17;
  // Number of iteration stages, one quotient bit each.
  localparam int NSTEP = 17;
  // Square-root iterations, one root bit each.
  localparam int SQ_STEPS = 16;

  // Operation codes.
  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_NEG  = 3'd4;
  localparam logic [2:0] MODE_CONJ = 3'd5;
  localparam logic [2:0] MODE_MAG  = 3'd6;

  // Saturated value with its overflow flag.
  typedef struct packed {
    logic               ovf;
    logic signed [15:0] val;
  } sat_t;

  // Contents of the product stage.
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [31:0] p3;
    logic signed [31:0] p4;
    logic signed [31:0] p5;
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               ovf;
    logic               dbz;
  } prod_t;

  // Contents of the combine stage and of each iteration stage.
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               ovf;
    logic               dbz;
    logic               neg_re;
    logic               neg_im;
    logic               big_re;
    logic               big_im;
    logic [NW-1:0]      n_re;
    logic [NW-1:0]      n_im;
    logic [31:0]        den;
    logic [QW-1:0]      q_re;
    logic [QW-1:0]      q_im;
    logic [31:0]        sx;
    logic [31:0]        sr;
  } pipe_t;

  // Clamp a wide signed value to the 16-bit range.
  function automatic sat_t sat16(input logic signed [49:0] v);
    sat_t s;
    if (v > 50'sd32767) begin
      s.ovf = 1'b1;
      s.val = 16'sh7FFF;
    end else if (v < -50'sd32768) begin
      s.ovf = 1'b1;
      s.val = 16'sh8000;
    end else begin
      s.ovf = 1'b0;
      s.val = v[15:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cau_front.sv -----
// Product stage and combine stage of the complex arithmetic unit.
// Depends on cau_pkg.
`default_nettype none
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
  input  wire                 clk,
  input  wire                 en_a,
  input  wire                 en_b,
  input  wire [2:0]           in_mode,
  input  wire signed [15:0]   in_a_real,
  input  wire signed [15:0]   in_a_imag,
  input  wire signed [15:0]   in_b_real,
  input  wire signed [15:0]   in_b_imag,
  output cau_pkg::pipe_t      b_q
);

  localparam int NW = cau_pkg::NW;
  localparam int QW = cau_pkg::QW;
  localparam logic [32:0] HALF = 33'((1 << FRAC_BITS) >> 1);

  // Drop the fraction bits, rounding to nearest with ties away from zero.
  function automatic logic signed [49:0] rnd_shift(input logic signed [32:0] x);
    logic [32:0] mag;
    logic [32:0] r;
    mag = x[32] ? 33'(-x) : 33'(x);
    r = (mag + HALF) >> FRAC_BITS;
    return x[32] ? -50'(r) : 50'(r);
  endfunction

  cau_pkg::prod_t a_nxt, a_r;
  cau_pkg::pipe_t b_nxt, b_r;
  logic signed [15:0] sq_x, sq_y;
  logic signed [16:0] t_re, t_im;
  cau_pkg::sat_t s_re, s_im, m_sre, m_sim;
  logic signed [32:0] m_re, m_im, d_re, d_im;
  logic [31:0] mag_re, mag_im, den;

  // Products, simple operations and the zero-divisor case.
  always_comb begin
    a_nxt = '0;
    a_nxt.mode = in_mode;
    sq_x = (in_mode == cau_pkg::MODE_MAG) ? in_a_real : in_b_real;
    sq_y = (in_mode == cau_pkg::MODE_MAG) ? in_a_imag : in_b_imag;
    a_nxt.p0 = in_a_real * in_b_real;
    a_nxt.p1 = in_a_imag * in_b_imag;
    a_nxt.p2 = in_a_real * in_b_imag;
    a_nxt.p3 = in_a_imag * in_b_real;
    a_nxt.p4 = sq_x * sq_x;
    a_nxt.p5 = sq_y * sq_y;
    t_re = '0;
    t_im = '0;
    unique case (in_mode)
      cau_pkg::MODE_ADD: begin
        t_re = 17'(in_a_real) + 17'(in_b_real);
        t_im = 17'(in_a_imag) + 17'(in_b_imag);
      end
      cau_pkg::MODE_SUB: begin
        t_re = 17'(in_a_real) - 17'(in_b_real);
        t_im = 17'(in_a_imag) - 17'(in_b_imag);
      end
      cau_pkg::MODE_NEG: begin
        t_re = -17'(in_a_real);
        t_im = -17'(in_a_imag);
      end
      cau_pkg::MODE_CONJ: begin
        t_re = 17'(in_a_real);
        t_im = -17'(in_a_imag);
      end
      default: begin
      end
    endcase
    s_re = cau_pkg::sat16(50'(t_re));
    s_im = cau_pkg::sat16(50'(t_im));
    a_nxt.res_re = s_re.val;
    a_nxt.res_im = s_im.val;
    a_nxt.ovf = s_re.ovf | s_im.ovf;
    if (in_mode == cau_pkg::MODE_DIV && in_b_real == 16'sd0 && in_b_imag == 16'sd0) begin
      a_nxt.dbz = 1'b1;
      a_nxt.res_re = (in_a_real > 16'sd0) ? 16'sh7FFF :
                     ((in_a_real < 16'sd0) ? 16'sh8000 : 16'sd0);
      a_nxt.res_im = (in_a_imag > 16'sd0) ? 16'sh7FFF :
                     ((in_a_imag < 16'sd0) ? 16'sh8000 : 16'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_r <= a_nxt;
    end
  end

  // Sums of products, multiply result, divide setup and square-root setup.
  always_comb begin
    m_re = 33'(a_r.p0) - 33'(a_r.p1);
    m_im = 33'(a_r.p2) + 33'(a_r.p3);
    d_re = 33'(a_r.p0) + 33'(a_r.p1);
    d_im = 33'(a_r.p3) - 33'(a_r.p2);
    den = $unsigned(a_r.p4) + $unsigned(a_r.p5);
    m_sre = cau_pkg::sat16(rnd_shift(m_re));
    m_sim = cau_pkg::sat16(rnd_shift(m_im));
    mag_re = d_re[32] ? 32'(-d_re) : 32'(d_re);
    mag_im = d_im[32] ? 32'(-d_im) : 32'(d_im);
    b_nxt = '0;
    b_nxt.mode = a_r.mode;
    b_nxt.dbz = a_r.dbz;
    if (a_r.mode == cau_pkg::MODE_MUL) begin
      b_nxt.res_re = m_sre.val;
      b_nxt.res_im = m_sim.val;
      b_nxt.ovf = m_sre.ovf | m_sim.ovf;
    end else begin
      b_nxt.res_re = a_r.res_re;
      b_nxt.res_im = a_r.res_im;
      b_nxt.ovf = a_r.ovf;
    end
    b_nxt.neg_re = d_re[32];
    b_nxt.neg_im = d_im[32];
    b_nxt.den = den;
    b_nxt.n_re = (NW'(mag_re) << FRAC_BITS) + NW'(den >> 1);
    b_nxt.n_im = (NW'(mag_im) << FRAC_BITS) + NW'(den >> 1);
    b_nxt.big_re = b_nxt.n_re >= (NW'(den) << QW);
    b_nxt.big_im = b_nxt.n_im >= (NW'(den) << QW);
    b_nxt.sx = den;
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_r <= b_nxt;
    end
  end

  assign b_q = b_r;

endmodule
`default_nettype wire

// ----- hw/rtl/cau_iter.sv -----
// One iteration stage: one restoring-divide bit for both parts and, while
// STEP is below SQ_STEPS, one square-root bit. Depends on cau_pkg.
`default_nettype none
module cau_iter #(
  parameter int STEP = 0
) (
  input  wire             clk,
  input  wire             en,
  input  cau_pkg::pipe_t  d,
  output cau_pkg::pipe_t  q
);

  localparam int NW = cau_pkg::NW;
  localparam int SHIFT = cau_pkg::QW - 1 - STEP;
  localparam int BPOS = (STEP < cau_pkg::SQ_STEPS) ? 30 - 2 * STEP : 0;
  localparam logic [31:0] BIT = 32'(1) << BPOS;

  cau_pkg::pipe_t d_nxt, q_r;
  logic [NW-1:0] dv_sh;
  logic [32:0] t;

  // Trial subtraction for each quotient, then one root step if STEP < SQ_STEPS.
  always_comb begin
    d_nxt = d;
    dv_sh = NW'(d.den) << SHIFT;
    if (d.n_re >= dv_sh) begin
      d_nxt.n_re = d.n_re - dv_sh;
      d_nxt.q_re[SHIFT] = 1'b1;
    end
    if (d.n_im >= dv_sh) begin
      d_nxt.n_im = d.n_im - dv_sh;
      d_nxt.q_im[SHIFT] = 1'b1;
    end
    t = {1'b0, d.sr} + {1'b0, BIT};
    if (STEP < cau_pkg::SQ_STEPS) begin
      if ({1'b0, d.sx} >= t) begin
        d_nxt.sx = d.sx - t[31:0];
        d_nxt.sr = (d.sr >> 1) + BIT;
      end else begin
        d_nxt.sr = d.sr >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= d_nxt;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ----- hw/rtl/cau_back.sv -----
// Result stage: sign and saturation of quotients, root rounding and the
// output register. Depends on cau_pkg.
`default_nettype none
module cau_back (
  input  wire                 clk,
  input  wire                 en,
  input  cau_pkg::pipe_t      d,
  output logic signed [15:0]  res_re,
  output logic signed [15:0]  res_im,
  output logic                ovf,
  output logic                dbz
);

  // Apply the sign to a quotient and saturate it.
  function automatic cau_pkg::sat_t div_res(input logic [cau_pkg::QW-1:0] qv,
                                            input logic neg, input logic big);
    cau_pkg::sat_t s;
    if (big) begin
      s.ovf = 1'b1;
      s.val = neg ? 16'sh8000 : 16'sh7FFF;
    end else begin
      s = cau_pkg::sat16(neg ? -50'(qv) : 50'(qv));
    end
    return s;
  endfunction

  logic signed [15:0] re_nxt, im_nxt, re_r, im_r;
  logic ovf_nxt, dbz_nxt, ovf_r, dbz_r;
  cau_pkg::sat_t s_re, s_im, s_mag;
  logic [16:0] root;

  // Select the final result by operation.
  always_comb begin
    s_re = div_res(d.q_re, d.neg_re, d.big_re);
    s_im = div_res(d.q_im, d.neg_im, d.big_im);
    root = 17'(d.sr[15:0]) + ((d.sx > d.sr) ? 17'd1 : 17'd0);
    s_mag = cau_pkg::sat16(50'(root));
    re_nxt = d.res_re;
    im_nxt = d.res_im;
    ovf_nxt = d.ovf;
    dbz_nxt = d.dbz;
    unique case (d.mode)
      cau_pkg::MODE_DIV: begin
        if (!d.dbz) begin
          re_nxt = s_re.val;
          im_nxt = s_im.val;
          ovf_nxt = s_re.ovf | s_im.ovf;
        end else begin
          ovf_nxt = 1'b0;
        end
      end
      cau_pkg::MODE_MAG: begin
        re_nxt = s_mag.val;
        im_nxt = 16'sd0;
        ovf_nxt = s_mag.ovf;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      ovf_r <= ovf_nxt;
      dbz_r <= dbz_nxt;
    end
  end

  assign res_re = re_r;
  assign res_im = im_r;
  assign ovf = ovf_r;
  assign dbz = dbz_r;

endmodule
`default_nettype wire

// ----- hw/rtl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit: add, sub, multiply, divide, negate, conjugate
// and magnitude on fixed-point complex operands. Depends on cau_pkg.
// Stages: product, combine, 17 divide/root iterations, result.
// Throughput is one transaction per cycle while out_ready is high; a stalled
// output holds its stage and idle stages ahead of it still fill.
// Synchronous active-low reset clears the stage valid bits only.
`default_nettype none
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire [2:0]          in_mode,
  input  wire signed [15:0]  in_a_real,
  input  wire signed [15:0]  in_a_imag,
  input  wire signed [15:0]  in_b_real,
  input  wire signed [15:0]  in_b_imag,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [15:0] out_res_real,
  output logic signed [15:0] out_res_imag,
  output logic               out_overflow,
  output logic               out_divide_by_zero
);

  localparam int NSTEP = cau_pkg::NSTEP;
  localparam int NS = NSTEP + 3;

  logic [NS-1:0] vld_r, vld_nxt;
  logic [NS:0] en;
  cau_pkg::pipe_t stg [0:NSTEP];

  // A stage loads when it is empty or the stage after it moves.
  assign en[NS] = out_ready;
  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = !vld_r[i] || en[i+1];
  end

  // Valid bits travel with the stage data.
  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NS; i++) begin
      vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .en_a      (en[0]),
    .en_b      (en[1]),
    .in_mode   (in_mode),
    .in_a_real (in_a_real),
    .in_a_imag (in_a_imag),
    .in_b_real (in_b_real),
    .in_b_imag (in_b_imag),
    .b_q       (stg[0])
  );

  // Divide and square-root iterations.
  for (genvar k = 0; k < NSTEP; k++) begin : g_iter
    cau_iter #(.STEP(k)) u_iter (
      .clk (clk),
      .en  (en[k+2]),
      .d   (stg[k]),
      .q   (stg[k+1])
    );
  end

  cau_back u_back (
    .clk    (clk),
    .en     (en[NS-1]),
    .d      (stg[NSTEP]),
    .res_re (out_res_real),
    .res_im (out_res_imag),
    .ovf    (out_overflow),
    .dbz    (out_divide_by_zero)
  );

  assign in_ready = en[0];
  assign out_valid = vld_r[NS-1];

endmodule
`default_nettype wire

// ----- hw/rtl/cau_checker.sv -----
// Port-level checks of the complex arithmetic unit and their bind.
// Depends on complex_arithmetic_unit.
`default_nettype none
module cau_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_ready,
  input wire [2:0]         in_mode,
  input wire signed [15:0] in_a_real,
  input wire signed [15:0] in_a_imag,
  input wire signed [15:0] in_b_real,
  input wire signed [15:0] in_b_imag,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [15:0] out_res_real,
  input wire signed [15:0] out_res_imag,
  input wire               out_overflow,
  input wire               out_divide_by_zero
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  // A zero divisor never reports overflow as well.
  a_dbz_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> !out_overflow)
    else $error("divide by zero reported together with overflow");

  // When the last stage moves or is empty, the whole pipeline can take input.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input not ready while pipeline can advance");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
`default_nettype wire
